/* rtl/gbi_pkg.sv */
// Shared types and constants for the grid bilinear interpolator.
`timescale 1ns / 1ps

package gbi_pkg;

    // Field widths fixed by the interface.
    localparam int COORD_W     = 24;
    localparam int VALUE_W     = 32;
    localparam int WIDX_W      = 6;
    localparam int POINTS_W    = 7;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    // Grid position: integer index and Q0.16 weight taken from a Q16.32 product.
    localparam int INDEX_W  = 16;
    localparam int FRAC_W   = 16;
    // A product of two Q1.16 weights reaches exactly 2^32, so it needs 33 bits.
    localparam int WEIGHT_W = 33;
    localparam int PROD_W   = 64;

    // Configuration register reset values.
    localparam logic [COORD_W-1:0]  RST_ENERGY_ORIGIN      = 24'd110762;
    localparam logic [COORD_W-1:0]  RST_ENERGY_STEP_RECIP  = 24'd32768;
    localparam logic [COORD_W-1:0]  RST_TEMP_ORIGIN        = 24'd6554;
    localparam logic [COORD_W-1:0]  RST_TEMP_STEP_RECIP    = 24'd3276800;
    localparam logic [POINTS_W-1:0] RST_ENERGY_POINTS_USED = 7'd41;
    localparam logic [POINTS_W-1:0] RST_TEMP_POINTS_USED   = 7'd51;

    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_LOOKUP = 1'b1
    } t_command;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ENERGY_ORIGIN      = 3'd0,
        CFG_ENERGY_STEP_RECIP  = 3'd1,
        CFG_TEMP_ORIGIN        = 3'd2,
        CFG_TEMP_STEP_RECIP    = 3'd3,
        CFG_ENERGY_POINTS_USED = 3'd4,
        CFG_TEMP_POINTS_USED   = 3'd5
    } t_cfg_index;

    // Load enables of the six pipeline stages.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } t_stage_en;

endpackage

/* rtl/gbi_position.sv */
// Maps one coordinate to a grid index and weight over two pipeline stages.
`timescale 1ns / 1ps

module gbi_position import gbi_pkg::*; (
    input  logic               i_clk,
    input  t_stage_en          i_en,
    input  logic [COORD_W-1:0] i_coord,
    input  logic [COORD_W-1:0] i_origin,
    input  logic [COORD_W-1:0] i_recip,
    output logic [INDEX_W-1:0] o_index,
    output logic [FRAC_W-1:0]  o_frac,
    output logic               o_below
);

    logic [COORD_W-1:0]   r_diff;
    logic                 r_below1;
    logic [COORD_W-1:0]   r_recip_hold;
    logic [2*COORD_W-1:0] n_pos;
    logic [INDEX_W-1:0]   r_index;
    logic [FRAC_W-1:0]    r_frac;
    logic                 r_below2;

    // Offset from the origin; the product is an unsigned Q16.32 position.
    assign n_pos = r_diff * r_recip_hold;

    // Stage 1: subtract the origin and note coordinates below it.
    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_diff       <= i_coord - i_origin;
            r_below1     <= (i_coord < i_origin);
            r_recip_hold <= i_recip;
        end
    end

    // Stage 2: scale by the reciprocal step; a coordinate below origin maps to 0.
    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_below2 <= r_below1;
            if (r_below1) begin
                r_index <= '0;
                r_frac  <= '0;
            end else begin
                r_index <= n_pos[2*COORD_W-1:2*COORD_W-INDEX_W];
                r_frac  <= n_pos[2*COORD_W-INDEX_W-1:2*COORD_W-INDEX_W-FRAC_W];
            end
        end
    end

    assign o_index = r_index;
    assign o_frac  = r_frac;
    assign o_below = r_below2;

endmodule

/* rtl/gbi_table.sv */
// Clamps grid indices, forms blend weights and reads four banked table neighbors.
`timescale 1ns / 1ps

module gbi_table import gbi_pkg::*; #(
    parameter int ENERGY_POINTS = 64,
    parameter int TEMP_POINTS   = 64
) (
    input  logic                         i_clk,
    input  t_stage_en                    i_en,
    input  logic                         i_valid,
    input  t_command                     i_command,
    input  logic [WIDX_W-1:0]            i_write_energy_index,
    input  logic [WIDX_W-1:0]            i_write_temp_index,
    input  logic [VALUE_W-1:0]           i_write_value,
    input  logic [INDEX_W-1:0]           i_energy_index,
    input  logic [FRAC_W-1:0]            i_energy_frac,
    input  logic                         i_energy_below,
    input  logic [INDEX_W-1:0]           i_temp_index,
    input  logic [FRAC_W-1:0]            i_temp_frac,
    input  logic                         i_temp_below,
    input  logic [POINTS_W-1:0]          i_energy_points_used,
    input  logic [POINTS_W-1:0]          i_temp_points_used,
    output t_command                     o_command,
    output logic                         o_out_of_range,
    output logic [1:0]                   o_parity,
    output logic [3:0][WEIGHT_W-1:0]     o_weight,
    output logic [3:0][VALUE_W-1:0]      o_bank_data
);

    // Entries are split by index parity into four banks, so the four neighbors
    // of any cell always sit in four different banks.
    localparam int E_ROWS     = (ENERGY_POINTS + 1) / 2;
    localparam int T_ROWS     = (TEMP_POINTS + 1) / 2;
    localparam int AE         = (E_ROWS > 1) ? $clog2(E_ROWS) : 1;
    localparam int AT         = (T_ROWS > 1) ? $clog2(T_ROWS) : 1;
    localparam int BANK_DEPTH = 1 << (AE + AT);
    localparam int WEXT_W     = 9;

    // Last usable index for a points-used setting, limited to the grid size.
    function automatic logic [INDEX_W-1:0] last_point(input logic [POINTS_W-1:0] used,
                                                     input logic [INDEX_W-1:0] cap);
        logic [INDEX_W-1:0] n;
        n = INDEX_W'(used);
        if (n < INDEX_W'(2)) begin
            n = INDEX_W'(2);
        end else if (n > cap) begin
            n = cap;
        end
        return n - INDEX_W'(1);
    endfunction

    logic [INDEX_W-1:0]  last_e;
    logic [INDEX_W-1:0]  last_t;
    logic                oor;
    logic [INDEX_W-1:0]  ie_c;
    logic [INDEX_W-1:0]  it_c;
    logic [INDEX_W-1:0]  ie_n;
    logic [INDEX_W-1:0]  it_n;
    logic [INDEX_W-1:0]  row_e [4];
    logic [INDEX_W-1:0]  row_t [4];
    logic [AE+AT-1:0]    rd_addr [4];
    logic [WEXT_W-1:0]   wie_x;
    logic [WEXT_W-1:0]   wit_x;
    logic [AE+AT-1:0]    wr_addr;
    logic [1:0]          wr_bank;
    logic                wr_en;
    logic [FRAC_W:0]     wx [2];
    logic [FRAC_W:0]     wy [2];
    logic [3:0][WEIGHT_W-1:0] n_weight;
    logic [VALUE_W-1:0]  r_data [4];
    logic [3:0][WEIGHT_W-1:0] r_weight;
    logic                r_out_of_range;
    logic [1:0]          r_parity;
    t_command            r_command;

    // Range check and clamping of both indices.
    always_comb begin
        last_e = last_point(i_energy_points_used, INDEX_W'(ENERGY_POINTS));
        last_t = last_point(i_temp_points_used, INDEX_W'(TEMP_POINTS));
        oor    = i_energy_below || i_temp_below ||
                 (i_energy_index >= last_e) || (i_temp_index >= last_t);
        ie_c   = (i_energy_index > last_e) ? last_e : i_energy_index;
        it_c   = (i_temp_index > last_t) ? last_t : i_temp_index;
        // A clamped lookup reads only its own cell; keep the neighbors in the grid.
        ie_n   = oor ? ie_c : ie_c + INDEX_W'(1);
        it_n   = oor ? it_c : it_c + INDEX_W'(1);
    end

    // Bank k holds energy parity k[1] and temperature parity k[0].
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            row_e[k]   = (ie_c[0] == k[1]) ? ie_c : ie_n;
            row_t[k]   = (it_c[0] == k[0]) ? it_c : it_n;
            rd_addr[k] = {row_e[k][AE:1], row_t[k][AT:1]};
        end
    end

    // Write address and bank; writes outside the grid are dropped.
    always_comb begin
        wie_x   = WEXT_W'(i_write_energy_index);
        wit_x   = WEXT_W'(i_write_temp_index);
        wr_addr = {wie_x[AE:1], wit_x[AT:1]};
        wr_bank = {wie_x[0], wit_x[0]};
        wr_en   = i_en.s3 && i_valid && (i_command == CMD_WRITE) &&
                  (wie_x < WEXT_W'(ENERGY_POINTS)) && (wit_x < WEXT_W'(TEMP_POINTS));
    end

    // Bilinear weights; neighbor n steps energy by n[1] and temperature by n[0].
    always_comb begin
        wx[0] = (FRAC_W+1)'(1 << FRAC_W) - (FRAC_W+1)'(i_energy_frac);
        wx[1] = (FRAC_W+1)'(i_energy_frac);
        wy[0] = (FRAC_W+1)'(1 << FRAC_W) - (FRAC_W+1)'(i_temp_frac);
        wy[1] = (FRAC_W+1)'(i_temp_frac);
        n_weight[0] = WEIGHT_W'(wx[0] * wy[0]);
        n_weight[1] = WEIGHT_W'(wx[0] * wy[1]);
        n_weight[2] = WEIGHT_W'(wx[1] * wy[0]);
        n_weight[3] = WEIGHT_W'(wx[1] * wy[1]);
    end

    // Four table banks, one write and one registered read per cycle.
    for (genvar k = 0; k < 4; k++) begin : g_bank
        logic [VALUE_W-1:0] r_mem [BANK_DEPTH];

        always_ff @(posedge i_clk) begin
            if (wr_en && (wr_bank == 2'(k))) begin
                r_mem[wr_addr] <= i_write_value;
            end
            if (i_en.s3) begin
                r_data[k] <= r_mem[rd_addr[k]];
            end
        end
    end

    // Stage 3 side registers that travel with the read data.
    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_weight       <= n_weight;
            r_out_of_range <= oor;
            r_parity       <= {ie_c[0], it_c[0]};
            r_command      <= i_command;
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            o_bank_data[k] = r_data[k];
        end
    end

    assign o_weight       = r_weight;
    assign o_out_of_range = r_out_of_range;
    assign o_parity       = r_parity;
    assign o_command      = r_command;

endmodule

/* rtl/gbi_blend.sv */
// Weights the four neighbors, sums them and selects the result over three stages.
`timescale 1ns / 1ps

module gbi_blend import gbi_pkg::*; (
    input  logic                     i_clk,
    input  t_stage_en                i_en,
    input  t_command                 i_command,
    input  logic                     i_out_of_range,
    input  logic [1:0]               i_parity,
    input  logic [3:0][WEIGHT_W-1:0] i_weight,
    input  logic [3:0][VALUE_W-1:0]  i_bank_data,
    output logic [VALUE_W-1:0]       o_rate_value,
    output logic                     o_out_of_range
);

    logic [3:0][PROD_W-1:0] n_prod;
    logic [3:0][PROD_W-1:0] r_prod;
    logic [VALUE_W-1:0]     r_cell4;
    logic                   r_oor4;
    t_command               r_cmd4;
    logic [PROD_W-1:0]      r_sum_lo;
    logic [PROD_W-1:0]      r_sum_hi;
    logic [VALUE_W-1:0]     r_cell5;
    logic                   r_oor5;
    t_command               r_cmd5;
    logic [PROD_W-1:0]      n_total;
    logic [VALUE_W-1:0]     r_rate_value;
    logic                   r_out_of_range;

    // Route bank data to neighbors by parity and weight them. A full weight of
    // 2^32 only occurs alone, so it becomes a shift instead of a wider multiply.
    always_comb begin
        logic [VALUE_W-1:0] q;
        for (int n = 0; n < 4; n++) begin
            q = i_bank_data[2'(n) ^ i_parity];
            if (i_weight[n][WEIGHT_W-1]) begin
                n_prod[n] = {q, VALUE_W'(0)};
            end else begin
                n_prod[n] = PROD_W'(q) * PROD_W'(i_weight[n][WEIGHT_W-2:0]);
            end
        end
    end

    // Stage 4: weighted neighbors.
    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_prod  <= n_prod;
            r_cell4 <= i_bank_data[i_parity];
            r_oor4  <= i_out_of_range;
            r_cmd4  <= i_command;
        end
    end

    // Stage 5: pairwise sums; the weights add up to 2^32, so nothing overflows.
    always_ff @(posedge i_clk) begin
        if (i_en.s5) begin
            r_sum_lo <= r_prod[0] + r_prod[1];
            r_sum_hi <= r_prod[2] + r_prod[3];
            r_cell5  <= r_cell4;
            r_oor5   <= r_oor4;
            r_cmd5   <= r_cmd4;
        end
    end

    assign n_total = r_sum_lo + r_sum_hi;

    // Stage 6: final sum truncated to Q16.16, or the clamped cell, or zero for writes.
    always_ff @(posedge i_clk) begin
        if (i_en.s6) begin
            if (r_cmd5 == CMD_WRITE) begin
                r_rate_value   <= '0;
                r_out_of_range <= 1'b0;
            end else if (r_oor5) begin
                r_rate_value   <= r_cell5;
                r_out_of_range <= 1'b1;
            end else begin
                r_rate_value   <= n_total[PROD_W-1:PROD_W-VALUE_W];
                r_out_of_range <= 1'b0;
            end
        end
    end

    assign o_rate_value   = r_rate_value;
    assign o_out_of_range = r_out_of_range;

endmodule

/* rtl/grid_bilinear_interpolator.sv */
// Top level of the grid bilinear interpolator: handshakes, configuration and pipeline control.
//
// Usage: the input channel (i_in_valid / o_in_ready) carries one transaction per item.
// A write command stores i_write_value at column i_write_energy_index and row
// i_write_temp_index; indices outside ENERGY_POINTS x TEMP_POINTS are ignored.
// A lookup maps i_energy and i_temperature to grid positions through the origin and
// reciprocal-step registers and returns the bilinear blend of the four neighbors, or
// the clamped cell with o_out_of_range set when a position falls outside the grid.
// Every transaction yields one output transaction (o_out_valid / i_out_ready); writes
// return zero. The configuration channel (i_cfg_valid / o_cfg_ready) is always ready
// and writes the register named by i_cfg_index; write it only while the block is idle.
// One item is taken every cycle unless the output stalls: the six-stage pipeline holds
// the 24x24 position multiply, the banked table read of four neighbors and the 32x32
// neighbor multiplies in separate stages. Reset empties the pipeline and restores
// register defaults; the table is not cleared and a lookup must only touch entries
// already written. When the receiver stalls, the output holds and stages behind it
// keep filling until the pipeline is full.
`timescale 1ns / 1ps

module grid_bilinear_interpolator import gbi_pkg::*; #(
    parameter int ENERGY_POINTS = 64,
    parameter int TEMP_POINTS   = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_command,
    input  logic [COORD_W-1:0]     i_energy,
    input  logic [COORD_W-1:0]     i_temperature,
    input  logic [WIDX_W-1:0]      i_write_energy_index,
    input  logic [WIDX_W-1:0]      i_write_temp_index,
    input  logic [VALUE_W-1:0]     i_write_value,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [VALUE_W-1:0]     o_rate_value,
    output logic                   o_out_of_range,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic [COORD_W-1:0]       r_energy_origin;
    logic [COORD_W-1:0]       r_energy_step_recip;
    logic [COORD_W-1:0]       r_temp_origin;
    logic [COORD_W-1:0]       r_temp_step_recip;
    logic [POINTS_W-1:0]      r_energy_points_used;
    logic [POINTS_W-1:0]      r_temp_points_used;

    logic [6:1]               r_valid;
    logic [6:1]               stage_ready;
    t_stage_en                en;

    t_command                 r_cmd1;
    t_command                 r_cmd2;
    logic [WIDX_W-1:0]        r_wie1;
    logic [WIDX_W-1:0]        r_wie2;
    logic [WIDX_W-1:0]        r_wit1;
    logic [WIDX_W-1:0]        r_wit2;
    logic [VALUE_W-1:0]       r_wval1;
    logic [VALUE_W-1:0]       r_wval2;

    logic [INDEX_W-1:0]       energy_index;
    logic [FRAC_W-1:0]        energy_frac;
    logic                     energy_below;
    logic [INDEX_W-1:0]       temp_index;
    logic [FRAC_W-1:0]        temp_frac;
    logic                     temp_below;

    t_command                 cmd3;
    logic                     oor3;
    logic [1:0]               parity3;
    logic [3:0][WEIGHT_W-1:0] weight3;
    logic [3:0][VALUE_W-1:0]  bank_data3;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_energy_origin      <= RST_ENERGY_ORIGIN;
            r_energy_step_recip  <= RST_ENERGY_STEP_RECIP;
            r_temp_origin        <= RST_TEMP_ORIGIN;
            r_temp_step_recip    <= RST_TEMP_STEP_RECIP;
            r_energy_points_used <= RST_ENERGY_POINTS_USED;
            r_temp_points_used   <= RST_TEMP_POINTS_USED;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_ENERGY_ORIGIN:      r_energy_origin      <= i_cfg_data;
                CFG_ENERGY_STEP_RECIP:  r_energy_step_recip  <= i_cfg_data;
                CFG_TEMP_ORIGIN:        r_temp_origin        <= i_cfg_data;
                CFG_TEMP_STEP_RECIP:    r_temp_step_recip    <= i_cfg_data;
                CFG_ENERGY_POINTS_USED: r_energy_points_used <= i_cfg_data[POINTS_W-1:0];
                CFG_TEMP_POINTS_USED:   r_temp_points_used   <= i_cfg_data[POINTS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // A stage may load when it is empty or the stage after it moves on.
    always_comb begin
        stage_ready[6] = ~r_valid[6] | i_out_ready;
        stage_ready[5] = ~r_valid[5] | stage_ready[6];
        stage_ready[4] = ~r_valid[4] | stage_ready[5];
        stage_ready[3] = ~r_valid[3] | stage_ready[4];
        stage_ready[2] = ~r_valid[2] | stage_ready[3];
        stage_ready[1] = ~r_valid[1] | stage_ready[2];
        en.s1 = stage_ready[1];
        en.s2 = stage_ready[2];
        en.s3 = stage_ready[3];
        en.s4 = stage_ready[4];
        en.s5 = stage_ready[5];
        en.s6 = stage_ready[6];
    end

    assign o_in_ready  = stage_ready[1];
    assign o_out_valid = r_valid[6];

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (stage_ready[1]) r_valid[1] <= i_in_valid;
            if (stage_ready[2]) r_valid[2] <= r_valid[1];
            if (stage_ready[3]) r_valid[3] <= r_valid[2];
            if (stage_ready[4]) r_valid[4] <= r_valid[3];
            if (stage_ready[5]) r_valid[5] <= r_valid[4];
            if (stage_ready[6]) r_valid[6] <= r_valid[5];
        end
    end

    // Command and write fields ride alongside the position stages.
    always_ff @(posedge i_clk) begin
        if (en.s1) begin
            r_cmd1  <= t_command'(i_command);
            r_wie1  <= i_write_energy_index;
            r_wit1  <= i_write_temp_index;
            r_wval1 <= i_write_value;
        end
        if (en.s2) begin
            r_cmd2  <= r_cmd1;
            r_wie2  <= r_wie1;
            r_wit2  <= r_wit1;
            r_wval2 <= r_wval1;
        end
    end

    gbi_position u_energy_pos (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_coord (i_energy),
        .i_origin(r_energy_origin),
        .i_recip (r_energy_step_recip),
        .o_index (energy_index),
        .o_frac  (energy_frac),
        .o_below (energy_below)
    );

    gbi_position u_temp_pos (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_coord (i_temperature),
        .i_origin(r_temp_origin),
        .i_recip (r_temp_step_recip),
        .o_index (temp_index),
        .o_frac  (temp_frac),
        .o_below (temp_below)
    );

    gbi_table #(
        .ENERGY_POINTS(ENERGY_POINTS),
        .TEMP_POINTS  (TEMP_POINTS)
    ) u_table (
        .i_clk               (i_clk),
        .i_en                (en),
        .i_valid             (r_valid[2]),
        .i_command           (r_cmd2),
        .i_write_energy_index(r_wie2),
        .i_write_temp_index  (r_wit2),
        .i_write_value       (r_wval2),
        .i_energy_index      (energy_index),
        .i_energy_frac       (energy_frac),
        .i_energy_below      (energy_below),
        .i_temp_index        (temp_index),
        .i_temp_frac         (temp_frac),
        .i_temp_below        (temp_below),
        .i_energy_points_used(r_energy_points_used),
        .i_temp_points_used  (r_temp_points_used),
        .o_command           (cmd3),
        .o_out_of_range      (oor3),
        .o_parity            (parity3),
        .o_weight            (weight3),
        .o_bank_data         (bank_data3)
    );

    gbi_blend u_blend (
        .i_clk         (i_clk),
        .i_en          (en),
        .i_command     (cmd3),
        .i_out_of_range(oor3),
        .i_parity      (parity3),
        .i_weight      (weight3),
        .i_bank_data   (bank_data3),
        .o_rate_value  (o_rate_value),
        .o_out_of_range(o_out_of_range)
    );

    // An accepted transaction always occupies the first stage next cycle.
    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_valid[1])
        else $error("accepted transaction did not enter stage 1");

    // A full pipeline facing a stalled receiver must refuse new input.
    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_valid) && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while pipeline is full and stalled");

    // A stalled item in stage 5 behind a waiting output is not dropped.
    a_no_drop_s5: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid[5] && r_valid[6] && !i_out_ready) |=> r_valid[5])
        else $error("stage 5 item lost during output stall");

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the grid bilinear interpolator: table load, lookups, register sets.
`timescale 1ns / 1ps

module testbench;
    import gbi_pkg::*;

    localparam int GRID_E          = 64;
    localparam int GRID_T          = 64;
    localparam int RANDOM_PHASES   = 7;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int IDLE_PCT        = 22;
    localparam int SETTLE_CYCLES   = 20;

    typedef enum bit {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        logic [VALUE_W-1:0] rate;
        logic               flag;
    } t_rate_result;

    // One stimulus step: either an input transaction or a register write.
    typedef struct packed {
        t_row_kind             kind;
        t_command              cmd;
        logic [COORD_W-1:0]    energy;
        logic [COORD_W-1:0]    temperature;
        logic [WIDX_W-1:0]     col;
        logic [WIDX_W-1:0]     row;
        logic [VALUE_W-1:0]    value;
        t_cfg_index            reg_index;
        logic [CFG_DATA_W-1:0] reg_data;
        logic                  typed;
        t_rate_result          want;
    } t_stim_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic                   i_command = 1'b0;
    logic [COORD_W-1:0]     i_energy = '0;
    logic [COORD_W-1:0]     i_temperature = '0;
    logic [WIDX_W-1:0]      i_write_energy_index = '0;
    logic [WIDX_W-1:0]      i_write_temp_index = '0;
    logic [VALUE_W-1:0]     i_write_value = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic [VALUE_W-1:0]     o_rate_value;
    logic                   o_out_of_range;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    grid_bilinear_interpolator #(
        .ENERGY_POINTS(GRID_E),
        .TEMP_POINTS  (GRID_T)
    ) uut (.*);

    // Mirror of the table and of the registers, kept in step with accepted transactions.
    logic [VALUE_W-1:0]  mirror_grid [GRID_E][GRID_T];
    logic [COORD_W-1:0]  energy_org = RST_ENERGY_ORIGIN;
    logic [COORD_W-1:0]  energy_rcp = RST_ENERGY_STEP_RECIP;
    logic [COORD_W-1:0]  temp_org   = RST_TEMP_ORIGIN;
    logic [COORD_W-1:0]  temp_rcp   = RST_TEMP_STEP_RECIP;
    logic [POINTS_W-1:0] energy_pts = RST_ENERGY_POINTS_USED;
    logic [POINTS_W-1:0] temp_pts   = RST_TEMP_POINTS_USED;

    t_rate_result pending_rates [$];
    t_stim_row    directed_rows [$];
    int           error_count = 0;
    bit           steady = 1'b0;

    // Clock generation.
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    // Points-used register as the block applies it: at least 2, at most the grid size.
    function automatic int usable_points(input logic [POINTS_W-1:0] v, input int cap);
        if (v < 2) return 2;
        if (int'(v) > cap) return cap;
        return int'(v);
    endfunction

    // Maps a coordinate onto the grid; returns 0 when it lies below the origin.
    function automatic bit axis_position(input logic [COORD_W-1:0] coord,
                                         input logic [COORD_W-1:0] org,
                                         input logic [COORD_W-1:0] rcp,
                                         output int idx, output logic [FRAC_W-1:0] frac);
        logic [63:0] pos;
        if (coord < org) begin
            idx = 0;
            frac = '0;
            return 1'b0;
        end
        pos = ({40'd0, coord} - {40'd0, org}) * {40'd0, rcp};
        idx = int'(pos[47:32]);
        frac = pos[31:16];
        return 1'b1;
    endfunction

    // Expected result of one transaction; a write also updates the mirror table.
    function automatic t_rate_result predict_rate(input t_stim_row s);
        t_rate_result res;
        int ne;
        int nt;
        int ie;
        int it;
        logic [FRAC_W-1:0] fx;
        logic [FRAC_W-1:0] fy;
        bit ok_e;
        bit ok_t;
        logic [63:0] wx0;
        logic [63:0] wx1;
        logic [63:0] wy0;
        logic [63:0] wy1;
        logic [63:0] sum;
        res = '0;
        if (s.cmd == CMD_WRITE) begin
            mirror_grid[s.col][s.row] = s.value;
            return res;
        end
        ne = usable_points(energy_pts, GRID_E);
        nt = usable_points(temp_pts, GRID_T);
        ok_e = axis_position(s.energy, energy_org, energy_rcp, ie, fx);
        ok_t = axis_position(s.temperature, temp_org, temp_rcp, it, fy);
        // Outside the grid: clamp an index past the last cell to it and raise the flag.
        if (!ok_e || !ok_t || ie >= ne - 1 || it >= nt - 1) begin
            if (ie > ne - 1) ie = ne - 1;
            if (it > nt - 1) it = nt - 1;
            res.rate = mirror_grid[ie][it];
            res.flag = 1'b1;
            return res;
        end
        // Bilinear blend; the four weights sum to 2^32, so the sum fits in 64 bits.
        wx1 = {48'd0, fx};
        wx0 = 64'd65536 - wx1;
        wy1 = {48'd0, fy};
        wy0 = 64'd65536 - wy1;
        sum = {32'd0, mirror_grid[ie][it]} * (wx0 * wy0)
            + {32'd0, mirror_grid[ie + 1][it]} * (wx1 * wy0)
            + {32'd0, mirror_grid[ie][it + 1]} * (wx0 * wy1)
            + {32'd0, mirror_grid[ie + 1][it + 1]} * (wx1 * wy1);
        res.rate = sum[63:32];
        return res;
    endfunction

    function automatic t_stim_row lookup_row(input logic [COORD_W-1:0] en,
                                             input logic [COORD_W-1:0] tp,
                                             input logic typed,
                                             input logic [VALUE_W-1:0] rate,
                                             input logic flag);
        t_stim_row s;
        s = '0;
        s.kind = ROW_ITEM;
        s.cmd = CMD_LOOKUP;
        s.energy = en;
        s.temperature = tp;
        s.typed = typed;
        s.want.rate = rate;
        s.want.flag = flag;
        return s;
    endfunction

    // A write always answers with zero and no flag.
    function automatic t_stim_row write_row(input logic [WIDX_W-1:0] col,
                                            input logic [WIDX_W-1:0] row,
                                            input logic [VALUE_W-1:0] value);
        t_stim_row s;
        s = '0;
        s.kind = ROW_ITEM;
        s.cmd = CMD_WRITE;
        s.col = col;
        s.row = row;
        s.value = value;
        s.typed = 1'b1;
        return s;
    endfunction

    function automatic t_stim_row reg_row(input t_cfg_index idx,
                                          input logic [CFG_DATA_W-1:0] data);
        t_stim_row s;
        s = '0;
        s.kind = ROW_CFG;
        s.cmd = CMD_WRITE;
        s.reg_index = idx;
        s.reg_data = data;
        return s;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_origin();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 14) return '1;
        return CFG_DATA_W'($urandom_range(0, 24'h3FFFFF));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_recip();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 14) return '1;
        return CFG_DATA_W'($urandom_range(24'h010000, 24'h3FFFFF));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_points();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return CFG_DATA_W'($urandom_range(0, 1));
        if (r < 20) return CFG_DATA_W'($urandom_range(GRID_E + 1, 127));
        return CFG_DATA_W'($urandom_range(2, GRID_E));
    endfunction

    // Coordinate that mostly lands on or just past the grid, with some below the origin.
    function automatic logic [COORD_W-1:0] pick_coord(input logic [COORD_W-1:0] org,
                                                      input logic [COORD_W-1:0] rcp,
                                                      input int npts);
        logic [63:0] span;
        logic [63:0] c;
        int r;
        r = $urandom_range(0, 99);
        if (r < 6 && org != 0) return COORD_W'($urandom_range(0, org - 1));
        if (r < 12) return COORD_W'($urandom());
        span = (rcp == 0) ? 64'hFFFFFF : ((64'(npts) << 32) / {40'd0, rcp});
        span = span + span / 8 + 1;
        c = {40'd0, org} + ({$urandom(), $urandom()} % span);
        return (c > 64'hFFFFFF) ? '1 : c[COORD_W-1:0];
    endfunction

    task automatic report_mismatch(input string field, input logic [VALUE_W-1:0] got,
                                   input logic [VALUE_W-1:0] want);
        $display("mismatch at %0t ns: %s got %h expected %h", $time, field, got, want);
        error_count++;
    endtask

    // Sends one input transaction and queues its expected result once accepted.
    task automatic send_item(input t_stim_row s);
        t_rate_result pred;
        i_cfg_valid <= 1'b0;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= s.cmd;
        i_energy <= s.energy;
        i_temperature <= s.temperature;
        i_write_energy_index <= s.col;
        i_write_temp_index <= s.row;
        i_write_value <= s.value;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pred = predict_rate(s);
        pending_rates.push_back(s.typed ? s.want : pred);
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (pending_rates.size() != 0) @(posedge i_clk);
    endtask

    // One register write; valid stays up so back-to-back writes need no gap.
    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_ENERGY_ORIGIN:      energy_org = data;
            CFG_ENERGY_STEP_RECIP:  energy_rcp = data;
            CFG_TEMP_ORIGIN:        temp_org = data;
            CFG_TEMP_STEP_RECIP:    temp_rcp = data;
            CFG_ENERGY_POINTS_USED: energy_pts = data[POINTS_W-1:0];
            CFG_TEMP_POINTS_USED:   temp_pts = data[POINTS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] e_org,
                                  input logic [CFG_DATA_W-1:0] e_rcp,
                                  input logic [CFG_DATA_W-1:0] t_org,
                                  input logic [CFG_DATA_W-1:0] t_rcp,
                                  input logic [CFG_DATA_W-1:0] e_pts,
                                  input logic [CFG_DATA_W-1:0] t_pts);
        wait_results_drained();
        write_reg(CFG_ENERGY_ORIGIN, e_org);
        write_reg(CFG_ENERGY_STEP_RECIP, e_rcp);
        write_reg(CFG_TEMP_ORIGIN, t_org);
        write_reg(CFG_TEMP_STEP_RECIP, t_rcp);
        write_reg(CFG_ENERGY_POINTS_USED, e_pts);
        write_reg(CFG_TEMP_POINTS_USED, t_pts);
    endtask

    // Receiver: random back-pressure, and each output transaction checked in order.
    always @(posedge i_clk) begin : result_check
        t_rate_result want;
        i_out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_rates.size() == 0) begin
                report_mismatch("unexpected result", o_rate_value, '0);
            end else begin
                want = pending_rates.pop_front();
                if (o_rate_value !== want.rate)
                    report_mismatch("rate_value", o_rate_value, want.rate);
                if (o_out_of_range !== want.flag)
                    report_mismatch("out_of_range", {31'd0, o_out_of_range}, {31'd0, want.flag});
            end
        end
    end

    initial begin : stimulus
        t_stim_row s;
        int phase;
        int n;

        // Directed rows; the table holds {col, row, 8000h} for every cell at this point.
        // Both coordinates below the origin, then far past the grid, then one of each, at reset settings.
        directed_rows.push_back(lookup_row(24'h000000, 24'h000000, 1'b1, 32'h0000_8000, 1'b1));
        directed_rows.push_back(lookup_row(24'hFFFFFF, 24'hFFFFFF, 1'b1, 32'h2832_8000, 1'b1));
        directed_rows.push_back(lookup_row(24'h000000, 24'hFFFFFF, 1'b1, 32'h0032_8000, 1'b1));
        directed_rows.push_back(lookup_row(24'hFFFFFF, 24'h000000, 1'b1, 32'h2800_8000, 1'b1));
        // Exactly on the origin: cell (0,0) with full weight.
        directed_rows.push_back(lookup_row(24'd110762, 24'd6554, 1'b1, 32'h0000_8000, 1'b0));
        // Full-scale and zero neighbors, then a blend between them.
        directed_rows.push_back(write_row(6'd5, 6'd7, 32'hFFFF_FFFF));
        directed_rows.push_back(write_row(6'd6, 6'd7, 32'h0000_0000));
        directed_rows.push_back(write_row(6'd5, 6'd8, 32'hFFFF_FFFF));
        directed_rows.push_back(write_row(6'd6, 6'd8, 32'h0000_0000));
        directed_rows.push_back(lookup_row(24'd110762 + 24'd667705, 24'd6554 + 24'd9568,
                                           1'b0, '0, 1'b0));
        // Row index landing exactly on points_used - 1, and just below it.
        directed_rows.push_back(lookup_row(24'd110762, 24'd6554 + 24'd65536,
                                           1'b1, 32'h0032_8000, 1'b1));
        directed_rows.push_back(lookup_row(24'd110762, 24'd6554 + 24'd65535, 1'b0, '0, 1'b0));
        directed_rows.push_back(write_row(6'd63, 6'd63, 32'h8000_0001));
        // Points-used below 2 and above the grid size.
        directed_rows.push_back(reg_row(CFG_ENERGY_POINTS_USED, 24'd0));
        directed_rows.push_back(reg_row(CFG_TEMP_POINTS_USED, 24'd127));
        directed_rows.push_back(lookup_row(24'hFFFFFF, 24'hFFFFFF, 1'b1, 32'h013F_8000, 1'b1));
        // Zero step reciprocal pins every position to the first cell.
        directed_rows.push_back(reg_row(CFG_ENERGY_STEP_RECIP, 24'd0));
        directed_rows.push_back(reg_row(CFG_TEMP_STEP_RECIP, 24'd0));
        directed_rows.push_back(lookup_row(24'hFFFFFF, 24'hFFFFFF, 1'b1, 32'h0000_8000, 1'b0));
        // Largest origins and reciprocals, one points-used of 1.
        directed_rows.push_back(reg_row(CFG_ENERGY_ORIGIN, 24'hFFFFFF));
        directed_rows.push_back(reg_row(CFG_TEMP_ORIGIN, 24'hFFFFFF));
        directed_rows.push_back(reg_row(CFG_ENERGY_STEP_RECIP, 24'hFFFFFF));
        directed_rows.push_back(reg_row(CFG_TEMP_STEP_RECIP, 24'hFFFFFF));
        directed_rows.push_back(reg_row(CFG_ENERGY_POINTS_USED, 24'd1));
        directed_rows.push_back(reg_row(CFG_TEMP_POINTS_USED, 24'd64));
        directed_rows.push_back(lookup_row(24'hFFFFFF, 24'hFFFFFF, 1'b1, 32'h0000_8000, 1'b0));
        directed_rows.push_back(lookup_row(24'hFFFFFE, 24'hFFFFFF, 1'b1, 32'h0000_8000, 1'b1));
        // Zero origins with the full grid: near-one weights and the far corner.
        directed_rows.push_back(reg_row(CFG_ENERGY_ORIGIN, 24'd0));
        directed_rows.push_back(reg_row(CFG_TEMP_ORIGIN, 24'd0));
        directed_rows.push_back(reg_row(CFG_ENERGY_POINTS_USED, 24'd64));
        directed_rows.push_back(lookup_row(24'h0000FF, 24'h000100, 1'b0, '0, 1'b0));
        directed_rows.push_back(lookup_row(24'h000000, 24'h000000, 1'b1, 32'h0000_8000, 1'b0));
        directed_rows.push_back(lookup_row(24'hFFFFFF, 24'hFFFFFF, 1'b1, 32'h8000_0001, 1'b1));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Load every cell so that no lookup can touch an unwritten entry.
        for (int col = 0; col < GRID_E; col++) begin
            for (int row = 0; row < GRID_T; row++) begin
                send_item(write_row(WIDX_W'(col), WIDX_W'(row),
                                    {2'b00, WIDX_W'(col), 2'b00, WIDX_W'(row), 16'h8000}));
            end
        end

        // Walk the directed table; register rows wait for the pipeline to empty.
        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == ROW_CFG) begin
                wait_results_drained();
                write_reg(directed_rows[k].reg_index, directed_rows[k].reg_data);
            end else begin
                send_item(directed_rows[k]);
            end
        end

        // Random phases, each under its own register settings.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: apply_settings(RST_ENERGY_ORIGIN, RST_ENERGY_STEP_RECIP, RST_TEMP_ORIGIN,
                                  RST_TEMP_STEP_RECIP, CFG_DATA_W'(RST_ENERGY_POINTS_USED),
                                  CFG_DATA_W'(RST_TEMP_POINTS_USED));
                1: apply_settings('0, '1, '0, '1, 24'd2, 24'd2);
                2: apply_settings(rand_origin(), rand_recip(), rand_origin(), rand_recip(),
                                  24'd64, 24'd64);
                default: apply_settings(rand_origin(), rand_recip(), rand_origin(),
                                        rand_recip(), rand_points(), rand_points());
            endcase
            // One phase runs with no idling on either side.
            steady = (phase == 4);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (phase == 3 && n == ITEMS_PER_PHASE / 2) wait_results_drained();
                if ($urandom_range(0, 99) < 25) begin
                    s = write_row(WIDX_W'($urandom_range(0, GRID_E - 1)),
                                  WIDX_W'($urandom_range(0, GRID_T - 1)),
                                  ($urandom_range(0, 9) == 0) ? {32{1'($urandom())}}
                                                              : $urandom());
                    s.energy = COORD_W'($urandom());
                    s.temperature = COORD_W'($urandom());
                end else begin
                    s = lookup_row(pick_coord(energy_org, energy_rcp,
                                              usable_points(energy_pts, GRID_E)),
                                   pick_coord(temp_org, temp_rcp,
                                              usable_points(temp_pts, GRID_T)),
                                   1'b0, '0, 1'b0);
                    s.col = WIDX_W'($urandom());
                    s.row = WIDX_W'($urandom());
                    s.value = $urandom();
                end
                send_item(s);
            end
        end

        wait_results_drained();
        steady = 1'b0;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* grid_bilinear_interpolator.f */
rtl/gbi_pkg.sv
rtl/gbi_position.sv
rtl/gbi_table.sv
rtl/gbi_blend.sv
rtl/grid_bilinear_interpolator.sv
tb/sv/testbench.sv
